// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files; the top level includes them.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== hw/rtl/orol_pkg.sv =====
// ----------------------------------------------------------------------------
// orol_pkg
// Types and constants of the overwriting ring with offset lookup.
// ----------------------------------------------------------------------------
package orol_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int HDL_W  = 32;
    localparam int SIZE_W = 16;
    localparam int OFF_W  = 20;
    // running byte total of the walked entries, one more entry included
    localparam int BEF_W  = SIZE_W + CNT_W;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_FIND = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [HDL_W-1:0]  entry_handle;
        logic [SIZE_W-1:0] entry_size;
        logic [OFF_W-1:0]  byte_pos;
    } t_in;

    typedef struct packed {
        logic              found;
        logic [HDL_W-1:0]  found_handle;
        logic [SIZE_W-1:0] found_size;
        logic [SIZE_W-1:0] byte_in_entry;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic add;      // write the entry, move the indices
        logic load;     // latch offset, start the walk at the oldest entry
        logic advance;  // move the walk address on
        logic accum;    // add compared size to total, one entry fewer left
        logic emit;     // capture the result
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic hit;       // compared entry holds the offset
        logic walk_end;  // no stored entry left to compare
    } t_dp_sts;

endpackage

// ===== hw/rtl/overwriting_ring_offset_lookup_top.sv =====
// ----------------------------------------------------------------------------
// overwriting_ring_offset_lookup_top
// Ring of entries (handle, byte size) with overwrite of the oldest entry and
// lookup of a byte offset into the concatenated entries.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low; i_item holds
//   the kind and the fields. An add writes the entry in the cycle it is
//   taken and gives no result; the next transaction may follow at once.
//   A full ring overwrites its oldest entry. A find walks the stored
//   entries from oldest to newest, one per cycle, out of the entry memory
//   with its registered read port. Busy is high from the cycle after the
//   start and is low again in the o_done cycle. o_done pulses for one
//   cycle with o_result; the find first primes the read of the oldest
//   entry, then compares entries until one matches or all stored entries
//   have been compared. The next transaction can be taken in the o_done
//   cycle. A not-found result has all fields zero. The receiver cannot hold
//   results off: o_result is valid only while o_done is high and holds its
//   value until the next find completes.
//   Synchronous reset empties the ring and returns the sequencer to idle;
//   entry contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module overwriting_ring_offset_lookup_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  orol_pkg::t_in   i_item,
    output logic            o_done,
    output orol_pkg::t_out  o_result
);

    orol_pkg::t_dp_cmd cmd;
    orol_pkg::t_dp_sts sts;

    orol_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_item.kind),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    orol_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_result)
    );

    // checks
    `ASSERT_PROP(a_find_goes_busy, i_clk, i_rst_n,
        start && !busy && (i_item.kind == orol_pkg::KIND_FIND) |=> busy,
        "find transaction did not start a walk")
    `ASSERT_PROP(a_done_after_busy, i_clk, i_rst_n,
        o_done |-> $past(busy) && !busy,
        "result strobe without a finished walk")
    `ASSERT_PROP(a_done_single, i_clk, i_rst_n,
        o_done |=> !o_done,
        "result strobe longer than one cycle")
    `ASSERT_PROP(a_miss_zero, i_clk, i_rst_n,
        o_done && !o_result.found |-> (o_result.found_handle == '0)
            && (o_result.found_size == '0) && (o_result.byte_in_entry == '0),
        "not-found result carries nonzero fields")

endmodule

// ===== hw/rtl/orol_datapath.sv =====
// ----------------------------------------------------------------------------
// orol_datapath
// Ring storage, ring indices, and the offset walk with its result register.
// ----------------------------------------------------------------------------
module orol_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  orol_pkg::t_in       i_item,
    input  orol_pkg::t_dp_cmd   i_cmd,
    output orol_pkg::t_dp_sts   o_sts,
    output orol_pkg::t_out      o_result
);

    localparam int IDX_W  = orol_pkg::IDX_W;
    localparam int CNT_W  = orol_pkg::CNT_W;
    localparam int SIZE_W = orol_pkg::SIZE_W;
    localparam int BEF_W  = orol_pkg::BEF_W;

    // entry storage, no reset
    logic [orol_pkg::HDL_W-1:0] mem_handle [orol_pkg::DEPTH];
    logic [SIZE_W-1:0]          mem_size   [orol_pkg::DEPTH];

    logic [IDX_W-1:0]           r_wr_idx, n_wr_idx;
    logic [IDX_W-1:0]           r_rd_idx, n_rd_idx;
    logic                       r_full, n_full;

    logic [IDX_W-1:0]           r_addr;
    logic [CNT_W-1:0]           r_left;
    logic [BEF_W-1:0]           r_before;
    logic [orol_pkg::OFF_W-1:0] r_offset;
    logic [orol_pkg::HDL_W-1:0] r_rd_handle;
    logic [SIZE_W-1:0]          r_rd_size;
    orol_pkg::t_out             r_result;

    logic [IDX_W-1:0]           wr_next;
    logic [IDX_W-1:0]           addr_next;
    logic [CNT_W-1:0]           count;
    logic [BEF_W-1:0]           end_pos;
    logic [BEF_W-1:0]           rel_pos;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] nxt;
        nxt = (idx == IDX_W'(orol_pkg::DEPTH - 1)) ? '0 : idx + 1'b1;
        return nxt;
    endfunction

    // stored entry count
    always_comb begin
        if (r_full) begin
            count = CNT_W'(orol_pkg::DEPTH);
        end else if (r_wr_idx >= r_rd_idx) begin
            count = CNT_W'(r_wr_idx) - CNT_W'(r_rd_idx);
        end else begin
            count = CNT_W'(orol_pkg::DEPTH) - CNT_W'(r_rd_idx) + CNT_W'(r_wr_idx);
        end
    end

    // add: index update, overwrite when full
    always_comb begin
        wr_next  = ring_next(r_wr_idx);
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_full   = r_full;
        if (i_cmd.add) begin
            n_wr_idx = wr_next;
            if (r_full) begin
                n_rd_idx = wr_next;
            end else if (wr_next == r_rd_idx) begin
                n_full = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_full   <= 1'b0;
        end else begin
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_full   <= n_full;
        end
    end

    // memory write and registered read at the walk address
    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            mem_handle[r_wr_idx] <= i_item.entry_handle;
            mem_size[r_wr_idx]   <= i_item.entry_size;
        end
        r_rd_handle <= mem_handle[r_addr];
        r_rd_size   <= mem_size[r_addr];
    end

    // compare of the entry just read
    assign addr_next = ring_next(r_addr);
    assign end_pos   = r_before + BEF_W'(r_rd_size);
    assign rel_pos   = BEF_W'(r_offset) - r_before;

    assign o_sts.walk_end = (r_left == '0);
    assign o_sts.hit      = (r_left != '0) && (r_rd_size != '0)
                            && (BEF_W'(r_offset) < end_pos);

    // walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr   <= r_rd_idx;
            r_left   <= count;
            r_before <= '0;
            r_offset <= i_item.byte_pos;
        end else begin
            if (i_cmd.advance) begin
                r_addr <= addr_next;
            end
            if (i_cmd.accum) begin
                r_before <= end_pos;
                r_left   <= r_left - 1'b1;
            end
        end
    end

    // result register, zeros when nothing matched
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (o_sts.hit) begin
                r_result.found         <= 1'b1;
                r_result.found_handle  <= r_rd_handle;
                r_result.found_size    <= r_rd_size;
                r_result.byte_in_entry <= rel_pos[SIZE_W-1:0];
            end else begin
                r_result <= '0;
            end
        end
    end

    assign o_result = r_result;

endmodule

// ===== hw/rtl/orol_ctrl.sv =====
// ----------------------------------------------------------------------------
// orol_ctrl
// Sequencer for add and find transactions, drives the datapath commands.
// ----------------------------------------------------------------------------
module orol_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_kind,
    input  orol_pkg::t_dp_sts  i_sts,
    output orol_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy,
    output logic               o_done
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIME,
        ST_WALK
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_kind == orol_pkg::KIND_FIND) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_PRIME;
                    end else begin
                        o_cmd.add = 1'b1;
                    end
                end
            end
            ST_PRIME: begin
                // first entry is being read
                o_cmd.advance = 1'b1;
                n_state       = ST_WALK;
            end
            ST_WALK: begin
                if (i_sts.hit || i_sts.walk_end) begin
                    o_cmd.emit = 1'b1;
                    n_done     = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    o_cmd.advance = 1'b1;
                    o_cmd.accum   = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;

endmodule
